// ----- rtl/lsdrs_pkg.sv -----
// Package for the typed-key LSD radix sorter.
// Holds key type codes, sequencer state enum and the key image mapping functions.
package lsdrs_pkg;

    localparam int KEY_W   = 64;
    localparam int POS_W   = 6;
    localparam int DIGIT_W = 8;
    localparam int BUCKETS = 256;

    typedef enum logic [1:0] {
        KT_UNSIGNED32 = 2'd0,
        KT_SIGNED32   = 2'd1,
        KT_FLOAT32    = 2'd2,
        KT_DOUBLE64   = 2'd3
    } key_type_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_IMAGE,
        ST_CLEAR,
        ST_COUNT,
        ST_PREFIX,
        ST_PLACE_RD,
        ST_PLACE_WR,
        ST_COPY,
        ST_EMIT_RD,
        ST_EMIT
    } sort_state_t;

    function automatic logic [KEY_W-1:0] to_image(input logic [KEY_W-1:0] k,
                                                  input key_type_t mode);
        logic [31:0] lo;
        lo = k[31:0];
        case (mode)
            KT_UNSIGNED32: to_image = {32'd0, lo};
            KT_SIGNED32:   to_image = {32'd0, lo ^ 32'h8000_0000};
            KT_FLOAT32:    to_image = lo[31] ? {32'd0, ~lo} : {32'd0, lo | 32'h8000_0000};
            default:       to_image = k[63] ? ~k : (k | 64'h8000_0000_0000_0000);
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] from_image(input logic [KEY_W-1:0] v,
                                                    input key_type_t mode);
        logic [31:0] lo;
        lo = v[31:0];
        case (mode)
            KT_UNSIGNED32: from_image = {32'd0, lo};
            KT_SIGNED32:   from_image = {32'd0, lo ^ 32'h8000_0000};
            KT_FLOAT32:    from_image = lo[31] ? {32'd0, lo & 32'h7FFF_FFFF} : {32'd0, ~lo};
            default:       from_image = v[63] ? (v & 64'h7FFF_FFFF_FFFF_FFFF) : ~v;
        endcase
    endfunction

endpackage

// ----- rtl/lsdrs_if.sv -----
// Valid/ready channel interfaces for the radix sorter.
// Depends on lsdrs_pkg for widths.
interface lsdrs_in_if
    import lsdrs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_bits;
    logic             batch_last;
    modport source (output valid, key_bits, batch_last, input ready);
    modport sink   (input valid, key_bits, batch_last, output ready);
endinterface

interface lsdrs_out_if
    import lsdrs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] sorted_key;
    logic [POS_W-1:0] source_position;
    logic             run_last;
    logic             overflowed;
    modport source (output valid, sorted_key, source_position, run_last, overflowed,
                    input ready);
    modport sink   (input valid, sorted_key, source_position, run_last, overflowed,
                    output ready);
endinterface

// ----- rtl/lsdrs_hist.sv -----
// 256-bucket digit histogram memory with registered read.
// Depends on lsdrs_pkg.
module lsdrs_hist
    import lsdrs_pkg::*;
#(
    parameter int CNT_W = 7
) (
    input  logic               clk,
    input  logic               we,
    input  logic [DIGIT_W-1:0] waddr,
    input  logic [CNT_W-1:0]   wdata,
    input  logic [DIGIT_W-1:0] raddr,
    output logic [CNT_W-1:0]   rdata
);
    logic [CNT_W-1:0] mem [BUCKETS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/lsd_radix_sort_typed_keys.sv -----
// Typed-key LSD radix sorter, top level.
// Depends on lsdrs_pkg, lsdrs_if and lsdrs_hist.
//
// Keys are loaded one per transaction (up to MAX_ITEMS; extras are dropped and
// flagged). A transaction with batch_last starts the sort: an image pass, then
// 4 passes (8 for doubles) of counting sort, each pass being histogram clear,
// count (key read one ahead, then read-modify-write on the single histogram
// memory), prefix sum, placement and copy back; results then stream out one at
// a time, each held until the output is ready. The histogram memory port sets
// the pace. Input is not ready during the sort and the output phase.
module lsd_radix_sort_typed_keys
    import lsdrs_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    lsdrs_in_if.sink    in_ch,
    lsdrs_out_if.source out_ch
);
    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int HC_W  = 7;

    sort_state_t state_reg, state_next;
    key_type_t   cfg_reg, mode_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               drop_reg;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [DIGIT_W:0]   bkt_reg, bkt_next;
    logic [2:0]         pass_reg;
    logic [HC_W-1:0]    acc_reg;
    logic               phase_reg;

    logic [KEY_W-1:0] key_mem [MAX_ITEMS];
    logic [KEY_W-1:0] scr_mem [MAX_ITEMS];
    logic [POS_W-1:0] pos_mem [MAX_ITEMS];
    logic [POS_W-1:0] spos_mem [MAX_ITEMS];
    logic [KEY_W-1:0] key_rd, scr_rd;
    logic [POS_W-1:0] pos_rd, spos_rd;

    logic               h_we;
    logic [DIGIT_W-1:0] h_waddr, h_raddr;
    logic [HC_W-1:0]    h_wdata, h_rdata;

    logic [IDX_W-1:0]   ridx;
    logic [DIGIT_W-1:0] digit;
    logic [5:0]         shamt;
    logic [HC_W-1:0]    slot;
    logic               last_pass;
    logic               accept;

    // Read index for the key stores; place walks backwards
    always_comb
    begin
        ridx = idx_reg[IDX_W-1:0];
        // count reads one key ahead so the histogram read sees the current key
        if (state_reg == ST_COUNT && phase_reg)
        begin
            ridx = IDX_W'(idx_reg + CNT_W'(1));
        end
    end

    assign accept = in_ch.valid && in_ch.ready;
    assign shamt  = {pass_reg, 3'b000};
    assign digit  = DIGIT_W'(key_rd >> shamt);
    assign slot   = h_rdata - HC_W'(1);
    assign last_pass = (mode_reg == KT_DOUBLE64) ? (pass_reg == 3'd7) : (pass_reg == 3'd3);

    lsdrs_hist #(.CNT_W(HC_W)) u_hist (
        .clk  (clk),
        .we   (h_we),
        .waddr(h_waddr),
        .wdata(h_wdata),
        .raddr(h_raddr),
        .rdata(h_rdata)
    );

    // Store memories: registered reads
    always_ff @(posedge clk)
    begin
        key_rd  <= key_mem[ridx];
        pos_rd  <= pos_mem[ridx];
        scr_rd  <= scr_mem[ridx];
        spos_rd <= spos_mem[ridx];
        if (state_reg == ST_LOAD && accept && count_reg < CNT_W'(MAX_ITEMS))
        begin
            key_mem[count_reg[IDX_W-1:0]] <= in_ch.key_bits;
            pos_mem[count_reg[IDX_W-1:0]] <= POS_W'(count_reg);
        end
        else if (state_reg == ST_IMAGE && phase_reg)
        begin
            key_mem[ridx] <= to_image(key_rd, mode_reg);
        end
        else if (state_reg == ST_COPY && phase_reg)
        begin
            key_mem[ridx] <= scr_rd;
            pos_mem[ridx] <= spos_rd;
        end
        if (state_reg == ST_PLACE_WR && slot < HC_W'(MAX_ITEMS))
        begin
            scr_mem[slot[IDX_W-1:0]]  <= key_rd;
            spos_mem[slot[IDX_W-1:0]] <= pos_rd;
        end
    end

    // Histogram port control
    always_comb
    begin
        h_we    = 1'b0;
        h_waddr = digit;
        h_wdata = h_rdata + HC_W'(1);
        h_raddr = digit;
        case (state_reg)
            ST_CLEAR:
            begin
                h_we    = 1'b1;
                h_waddr = bkt_reg[DIGIT_W-1:0];
                h_wdata = '0;
            end
            ST_COUNT:
            begin
                h_we = phase_reg;
            end
            ST_PREFIX:
            begin
                h_raddr = bkt_reg[DIGIT_W-1:0];
                h_waddr = bkt_reg[DIGIT_W-1:0];
                h_wdata = h_rdata + acc_reg;
                h_we    = phase_reg;
            end
            ST_PLACE_WR:
            begin
                h_we    = 1'b1;
                h_wdata = slot;
            end
            default:
            begin
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        bkt_next   = bkt_reg;
        case (state_reg)
            ST_LOAD:
            begin
                idx_next = '0;
                if (accept && in_ch.batch_last)
                begin
                    state_next = ST_IMAGE;
                end
            end
            ST_IMAGE:
            begin
                if (phase_reg)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (phase_reg && idx_reg + CNT_W'(1) >= count_reg)
                begin
                    state_next = ST_CLEAR;
                    bkt_next   = '0;
                    idx_next   = '0;
                end
                else if (count_reg == '0)
                begin
                    state_next = ST_EMIT_RD;
                    idx_next   = '0;
                end
            end
            ST_CLEAR:
            begin
                bkt_next = bkt_reg + (DIGIT_W+1)'(1);
                if (bkt_reg[DIGIT_W])
                begin
                    state_next = ST_COUNT;
                    idx_next   = '0;
                end
            end
            ST_COUNT:
            begin
                if (phase_reg)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    if (idx_reg + CNT_W'(1) >= count_reg)
                    begin
                        state_next = ST_PREFIX;
                        bkt_next   = '0;
                    end
                end
            end
            ST_PREFIX:
            begin
                if (phase_reg)
                begin
                    bkt_next = bkt_reg + (DIGIT_W+1)'(1);
                    if (bkt_reg[DIGIT_W-1:0] == DIGIT_W'(BUCKETS - 1))
                    begin
                        state_next = ST_PLACE_RD;
                        idx_next   = count_reg - CNT_W'(1);
                    end
                end
            end
            ST_PLACE_RD:
            begin
                if (phase_reg)
                begin
                    state_next = ST_PLACE_WR;
                end
            end
            ST_PLACE_WR:
            begin
                if (idx_reg == '0)
                begin
                    state_next = ST_COPY;
                end
                else
                begin
                    state_next = ST_PLACE_RD;
                    idx_next   = idx_reg - CNT_W'(1);
                end
            end
            ST_COPY:
            begin
                if (phase_reg)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    if (idx_reg + CNT_W'(1) >= count_reg)
                    begin
                        idx_next = '0;
                        if (last_pass)
                        begin
                            state_next = ST_EMIT_RD;
                        end
                        else
                        begin
                            state_next = ST_CLEAR;
                            bkt_next   = '0;
                        end
                    end
                end
            end
            ST_EMIT_RD:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_LOAD;
                end
                else if (phase_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_ch.ready)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    if (idx_reg + CNT_W'(1) >= count_reg)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ch.ready            = (state_reg == ST_LOAD);
        out_ch.valid           = (state_reg == ST_EMIT);
        out_ch.sorted_key      = from_image(key_rd, mode_reg);
        out_ch.source_position = pos_rd;
        out_ch.run_last        = (idx_reg + CNT_W'(1) == count_reg);
        out_ch.overflowed      = drop_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cfg_reg   <= KT_UNSIGNED32;
            mode_reg  <= KT_UNSIGNED32;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            idx_reg   <= '0;
            bkt_reg   <= '0;
            pass_reg  <= '0;
            acc_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            bkt_reg   <= bkt_next;
            if (cfg_we)
            begin
                cfg_reg <= key_type_t'(cfg_wdata);
            end
            // phase toggles while the state holds, restarts on state change
            if (state_next != state_reg)
            begin
                phase_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= ~phase_reg;
            end
            case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        if (count_reg < CNT_W'(MAX_ITEMS))
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            drop_reg <= 1'b1;
                        end
                        if (in_ch.batch_last)
                        begin
                            mode_reg <= cfg_reg;
                            pass_reg <= '0;
                        end
                    end
                end
                ST_PREFIX:
                begin
                    if (phase_reg)
                    begin
                        acc_reg <= h_rdata + acc_reg;
                    end
                end
                ST_COUNT:
                begin
                    acc_reg <= '0;
                end
                ST_COPY:
                begin
                    if (phase_reg && idx_reg + CNT_W'(1) >= count_reg)
                    begin
                        pass_reg <= pass_reg + 3'd1;
                    end
                end
                default:
                begin
                end
            endcase
            if (state_next == ST_LOAD && state_reg != ST_LOAD)
            begin
                count_reg <= '0;
                drop_reg  <= 1'b0;
            end
        end
    end

endmodule

// ----- tb/sv/lsdrs_checker.sv -----
// Result checker for the typed-key radix sorter: watches both channels,
// predicts each sorted batch and compares. Depends on lsdrs_pkg and lsdrs_if.
`timescale 1ns / 100ps
module lsdrs_checker
    import lsdrs_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    lsdrs_in_if         in_ch,
    lsdrs_out_if        out_ch,
    output int          fail_count,
    output int          pending,
    output int          result_count
);

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
        logic             last;
        logic             ovf;
    } sort_result_t;

    sort_result_t      sorted_q[$];
    logic [KEY_W-1:0]  batch_keys[$];
    logic              batch_dropped;
    key_type_t         mode_reg;

    function automatic logic [KEY_W-1:0] ordering_image(logic [KEY_W-1:0] k, key_type_t m);
        logic [31:0] lo;
        lo = k[31:0];
        case (m)
            KT_UNSIGNED32: return {32'd0, lo};
            KT_SIGNED32:   return {32'd0, lo ^ 32'h8000_0000};
            KT_FLOAT32:    return lo[31] ? {32'd0, ~lo} : {32'd0, lo | 32'h8000_0000};
            default:       return k[63] ? ~k : {1'b1, k[62:0]};
        endcase
    endfunction

    // stable insertion sort on images gives the same order as the radix sort
    task automatic predict_batch();
        logic [KEY_W-1:0] img[$];
        int               pos[$];
        logic [KEY_W-1:0] ti;
        int               tp;
        int               j;
        sort_result_t     r;
        for (int i = 0; i < batch_keys.size(); i++)
        begin
            img.push_back(ordering_image(batch_keys[i], mode_reg));
            pos.push_back(i);
        end
        for (int i = 1; i < img.size(); i++)
        begin
            ti = img[i];
            tp = pos[i];
            j = i - 1;
            while (j >= 0 && img[j] > ti)
            begin
                img[j+1] = img[j];
                pos[j+1] = pos[j];
                j--;
            end
            img[j+1] = ti;
            pos[j+1] = tp;
        end
        for (int i = 0; i < img.size(); i++)
        begin
            r.key  = (mode_reg == KT_DOUBLE64) ? batch_keys[pos[i]]
                                               : {32'd0, batch_keys[pos[i]][31:0]};
            r.pos  = POS_W'(pos[i]);
            r.last = (i == img.size() - 1);
            r.ovf  = batch_dropped;
            sorted_q.push_back(r);
        end
        batch_keys.delete();
        batch_dropped = 1'b0;
    endtask

    assign pending = sorted_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        sort_result_t e;
        if (!rst_n)
        begin
            mode_reg      <= KT_UNSIGNED32;
            batch_dropped = 1'b0;
            batch_keys.delete();
            sorted_q.delete();
            fail_count    <= 0;
            result_count  <= 0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= key_type_t'(cfg_wdata);
            if (in_ch.valid && in_ch.ready)
            begin
                if (batch_keys.size() < MAX_ITEMS)
                    batch_keys.push_back(in_ch.key_bits);
                else
                    batch_dropped = 1'b1;
                if (in_ch.batch_last)
                    predict_batch();
            end
            if (out_ch.valid && out_ch.ready)
            begin
                result_count <= result_count + 1;
                if (sorted_q.size() == 0)
                begin
                    $error("unexpected result transaction, key %h", out_ch.sorted_key);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = sorted_q.pop_front();
                    if (out_ch.sorted_key !== e.key || out_ch.source_position !== e.pos ||
                        out_ch.run_last !== e.last || out_ch.overflowed !== e.ovf)
                    begin
                        fail_count <= fail_count + 1;
                        if (out_ch.sorted_key !== e.key)
                            $error("sorted_key: expected %h, got %h", e.key, out_ch.sorted_key);
                        if (out_ch.source_position !== e.pos)
                            $error("source_position: expected %0d, got %0d",
                                   e.pos, out_ch.source_position);
                        if (out_ch.run_last !== e.last)
                            $error("run_last: expected %b, got %b", e.last, out_ch.run_last);
                        if (out_ch.overflowed !== e.ovf)
                            $error("overflowed: expected %b, got %b", e.ovf, out_ch.overflowed);
                    end
                end
            end
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top-level testbench for the typed-key radix sorter: clock, reset, stimulus
// and verdict. Depends on lsdrs_pkg, lsdrs_if and lsdrs_checker.
`timescale 1ns / 100ps
module testbench;
    import lsdrs_pkg::*;

    localparam int MAX_ITEMS   = 64;
    localparam int STALL_LIMIT = 50000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_wdata = '0;
    int   fail_count, pending, result_count;
    int   idle_cycles = 0;
    int   items_sent = 0;
    int   batches = 0;
    bit   calm = 1'b0;

    lsdrs_in_if  in_ch();
    lsdrs_out_if out_ch();

    lsd_radix_sort_typed_keys #(.MAX_ITEMS(MAX_ITEMS)) i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    lsdrs_checker #(.MAX_ITEMS(MAX_ITEMS)) i_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_ch(in_ch), .out_ch(out_ch), .fail_count(fail_count),
        .pending(pending), .result_count(result_count)
    );

    always #2 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.key_bits = '0;
        in_ch.batch_last = 1'b0;
        out_ch.ready = 1'b0;
    end

    // result-side back-pressure
    always @(posedge clk)
        out_ch.ready <= calm || ($urandom_range(99) >= 15);

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_key(logic [KEY_W-1:0] k, logic lst);
        while (!calm && $urandom_range(99) < 15)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.key_bits <= k;
        in_ch.batch_last <= lst;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
        if (lst)
        begin
            batches++;
            // drop valid before the sorter returns to loading
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic set_key_type(key_type_t kt);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= kt;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] rand_key(key_type_t kt);
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        case ($urandom_range(7))
            0: k = '0;
            1: k = '1;
            2: k = (kt == KT_DOUBLE64) ? 64'h8000_0000_0000_0000 : {$urandom, 32'h8000_0000};
            3: k = (kt == KT_DOUBLE64) ? {12'h7FF, k[51:0]} : {k[63:32], 9'h0FF, k[22:0]};
            4: k = {k[63:8], 8'($urandom_range(3))};   // shared digits, ties
            default: ;
        endcase
        return k;
    endfunction

    task automatic send_batch(key_type_t kt, int n);
        for (int i = 0; i < n; i++)
            send_key(rand_key(kt), i == n - 1);
    endtask

    initial
    begin
        int n;
        key_type_t kt;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, signed zeros, NaNs, ties, config write mid-batch
        send_key(64'h0, 1'b1);
        send_key(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_key(64'h0, 1'b0);
        send_key(64'h0000_0000_8000_0000, 1'b0);
        send_key(64'h0000_0000_7FFF_FFFF, 1'b1);
        set_key_type(KT_SIGNED32);
        send_key(64'h0000_0000_8000_0000, 1'b0);
        send_key(64'h0000_0000_7FFF_FFFF, 1'b0);
        send_key(64'h1234_5678_FFFF_FFFF, 1'b0);
        send_key(64'h0000_0000_7FFF_FFFF, 1'b1);
        set_key_type(KT_FLOAT32);
        send_key(64'h0000_0000_8000_0000, 1'b0);
        send_key(64'h0000_0000_0000_0000, 1'b0);
        send_key(64'h0000_0000_FFC0_0000, 1'b0);
        send_key(64'h0000_0000_7FC0_0000, 1'b0);
        send_key(64'h0000_0000_BF80_0000, 1'b1);
        set_key_type(KT_DOUBLE64);
        send_key(64'h8000_0000_0000_0000, 1'b0);
        send_key(64'h0000_0000_0000_0000, 1'b0);
        send_key(64'hFFF8_0000_0000_0000, 1'b0);
        send_key(64'h7FF8_0000_0000_0001, 1'b0);
        in_ch.valid <= 1'b0;
        cfg_we <= 1'b1;                 // only the value at sort start counts
        cfg_wdata <= KT_DOUBLE64;
        @(posedge clk);
        cfg_we <= 1'b0;
        send_key(64'hBFF0_0000_0000_0000, 1'b1);

        // overflow batch: more keys than capacity
        set_key_type(KT_UNSIGNED32);
        send_batch(KT_UNSIGNED32, MAX_ITEMS + 3);

        // random batches, mostly small, across all key types
        while (items_sent < 430)
        begin
            kt = key_type_t'($urandom_range(3));
            set_key_type(kt);
            calm = (batches % 7 == 3);
            case ($urandom_range(9))
                0:       n = MAX_ITEMS;
                1:       n = MAX_ITEMS + $urandom_range(1, 3);
                default: n = $urandom_range(1, 12);
            endcase
            send_batch(kt, n);
        end
        calm = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Covered %0d keys in %0d batches, %0d sorted results checked.",
                 items_sent, batches, result_count);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- lsd_radix_sort_typed_keys.f -----
rtl/lsdrs_pkg.sv
rtl/lsdrs_if.sv
rtl/lsdrs_hist.sv
rtl/lsd_radix_sort_typed_keys.sv
tb/sv/lsdrs_checker.sv
tb/sv/testbench.sv
